// ----- src/etbc_pkg.sv -----
// Shared types and constants for the evolving-table byte cipher.
// No dependencies; the top level and etbc_mul refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package etbc_pkg;

   // request codes
   localparam logic [2:0] REQ_ENCRYPT = 3'd0;
   localparam logic [2:0] REQ_DECRYPT = 3'd1;
   localparam logic [2:0] REQ_INIT    = 3'd2;
   localparam logic [2:0] REQ_RESET   = 3'd3;
   localparam logic [2:0] REQ_FPRINT  = 3'd4;

   // configuration register indexes
   localparam logic [1:0] CSR_SEED = 2'd0;
   localparam logic [1:0] CSR_JUMP = 2'd1;
   localparam logic [1:0] CSR_MASK = 2'd2;

   localparam logic [31:0] FNV_BASIS = 32'd2166136261;
   localparam logic [31:0] FNV_PRIME = 32'd16777619;
   localparam logic [8:0]  MOD_LAST  = 9'd256;   // i mod 257 wraps after this
   localparam int          FOLD_SHIFT = 13;
   // only the low byte of v ^ (v >> 13) is kept, so v is needed to bit 20
   localparam int          INIT_W = FOLD_SHIFT + 8;

   // multiplier modes
   localparam logic MUL_INIT = 1'b0;
   localparam logic MUL_FNV  = 1'b1;

   typedef struct packed {
      logic              mode;
      logic [31:0]       hash;
      logic [7:0]        data;
      logic [INIT_W-1:0] init_a;
      logic [INIT_W-1:0] init_b;
   } mul_req_type;

endpackage

`default_nettype wire

// ----- src/etbc_intf.sv -----
// Valid/ready channel interfaces for request and response items.
// Depends on nothing; used by the top level of the byte cipher.
`timescale 1ns / 1ps
`default_nettype none

interface etbc_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] req_type;
   logic [7:0] data_byte;
   modport source (output valid, output req_type, output data_byte, input ready);
   modport sink (input valid, input req_type, input data_byte, output ready);
endinterface

interface etbc_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  result_byte;
   logic [31:0] fingerprint;
   modport source (output valid, output result_byte, output fingerprint, input ready);
   modport sink (input valid, input result_byte, input fingerprint, output ready);
endinterface

`default_nettype wire

// ----- src/evolving_table_byte_cipher.sv -----
// Top level of the evolving-table byte cipher: sequencer, state and result register.
// Depends on etbc_pkg, etbc_intf (channels), etbc_mem and etbc_mul.
//
//  channel  | dir | payload                          | handshake
//  ---------+-----+----------------------------------+-----------------------
//  req_ch   | in  | req_type[2:0], data_byte[7:0]    | valid/ready
//  rsp_ch   | out | result_byte[7:0], fingerprint[31:0] | valid/ready
//  csr_*    | in  | csr_index[1:0], csr_wdata[63:0]  | csr_we, always taken
//
// Steps per item (the table has a single read port, the multiplier is shared):
//   encrypt/decrypt: key read, pointer read, mutate, result; reset position /
//   unused code: result; init: multiply, write per entry; fingerprint: hash sweep.
// After reset a clearing pass zeroes the table, with req not ready.
// Reset is synchronous, active high. One item at a time; a new item is taken
// while the previous result still waits in the output register.
`timescale 1ns / 1ps
`default_nettype none

module evolving_table_byte_cipher #(
   parameter int TABLE_SIZE = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   etbc_req_if.sink         req_ch,
   etbc_rsp_if.source       rsp_ch,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [63:0] csr_wdata
);

   localparam int AW = $clog2(TABLE_SIZE);
   localparam int CW = AW + 1;                  // sweep counter, holds TABLE_SIZE
   localparam int SW = ((AW > 8) ? AW : 8) + 1; // pointer advance sum

   // sequencer codes
   localparam logic [3:0] S_CLEAR    = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_RD_KEY   = 4'd2;
   localparam logic [3:0] S_RD_PTR   = 4'd3;
   localparam logic [3:0] S_MUTATE   = 4'd4;
   localparam logic [3:0] S_INIT_MUL = 4'd5;
   localparam logic [3:0] S_INIT_WR  = 4'd6;
   localparam logic [3:0] S_HASH     = 4'd7;
   localparam logic [3:0] S_DONE     = 4'd8;

   localparam logic [CW-1:0] SWEEP_END = CW'(TABLE_SIZE);
   localparam logic [AW-1:0] IDX_LAST  = AW'(TABLE_SIZE - 1);

   // config registers
   logic [63:0] seed_ff;
   logic [31:0] jump_ff;
   logic [7:0]  mask_ff;

   // control
   logic [3:0]    state_ff, state_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [8:0]    m257_ff, m257_in;       // index mod 257 during init
   logic [AW-1:0] ptr_ff, ptr_in;
   logic [31:0]   cnt_ff, cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // payload
   logic [2:0]              type_ff, type_in;
   logic [7:0]              data_ff, data_in;
   logic [7:0]              out_ff, out_in;
   logic [7:0]              c_ff, c_in;
   logic [31:0]             hash_ff, hash_in;
   logic [etbc_pkg::INIT_W-1:0] prod_ff, prod_in;
   logic [7:0]              rsp_byte_ff, rsp_byte_in;
   logic [31:0]             rsp_fp_ff, rsp_fp_in;

   // table and multiplier hookup
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic [AW-1:0] rd_addr;
   logic [7:0]    rd_data;
   etbc_pkg::mul_req_type mul_op;
   logic [31:0]   mul_out;

   logic          req_take;
   logic          rsp_free;
   logic [7:0]    crypt_out;
   logic [SW-1:0] ptr_sum;

   etbc_mem #(
      .DEPTH (TABLE_SIZE),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   etbc_mul u_mul (
      .op      (mul_op),
      .product (mul_out)
   );

   assign req_ch.ready       = (state_ff == S_IDLE);
   assign req_take           = req_ch.valid && (state_ff == S_IDLE);
   assign rsp_free           = !rsp_valid_ff || rsp_ch.ready;
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.result_byte = rsp_byte_ff;
   assign rsp_ch.fingerprint = rsp_fp_ff;

   // key byte arrives in S_RD_PTR; decrypt mutates with the incoming byte
   assign crypt_out = data_ff ^ rd_data;
   assign ptr_sum   = SW'(ptr_ff) + SW'(c_ff) + SW'(1);

   always_comb begin
      mul_op.mode   = (state_ff == S_HASH) ? etbc_pkg::MUL_FNV : etbc_pkg::MUL_INIT;
      mul_op.hash   = hash_ff;
      mul_op.data   = rd_data;
      mul_op.init_a = seed_ff[etbc_pkg::INIT_W-1:0]
                      ^ etbc_pkg::INIT_W'(idx_ff[AW-1:0]);
      mul_op.init_b = jump_ff[etbc_pkg::INIT_W-1:0] + etbc_pkg::INIT_W'(m257_ff);
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      m257_in      = m257_ff;
      ptr_in       = ptr_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      type_in      = type_ff;
      data_in      = data_ff;
      out_in       = out_ff;
      c_in         = c_ff;
      hash_in      = hash_ff;
      prod_in      = prod_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_fp_in    = rsp_fp_ff;
      wr_en        = 1'b0;
      wr_addr      = ptr_ff;
      wr_data      = '0;
      rd_addr      = ptr_ff;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[AW-1:0];
            wr_data = '0;
            idx_in  = idx_ff + CW'(1);
            if (idx_ff[AW-1:0] == IDX_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_take) begin
               type_in = req_ch.req_type;
               data_in = req_ch.data_byte;
               idx_in  = '0;
               m257_in = '0;
               unique case (req_ch.req_type)
                  etbc_pkg::REQ_ENCRYPT,
                  etbc_pkg::REQ_DECRYPT: state_in = S_RD_KEY;
                  etbc_pkg::REQ_INIT:    state_in = S_INIT_MUL;
                  etbc_pkg::REQ_RESET: begin
                     ptr_in   = '0;
                     cnt_in   = '0;
                     state_in = S_DONE;
                  end
                  etbc_pkg::REQ_FPRINT: begin
                     hash_in  = etbc_pkg::FNV_BASIS;
                     state_in = S_HASH;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_RD_KEY: begin
            // key index = (pointer + counter) mod 2**AW
            rd_addr  = ptr_ff + cnt_ff[AW-1:0];
            state_in = S_RD_PTR;
         end
         S_RD_PTR: begin
            out_in   = crypt_out;
            c_in     = (type_ff == etbc_pkg::REQ_DECRYPT) ? data_ff : crypt_out;
            rd_addr  = ptr_ff;
            state_in = S_MUTATE;
         end
         S_MUTATE: begin
            wr_en    = 1'b1;
            wr_addr  = ptr_ff;
            wr_data  = rd_data ^ c_ff ^ cnt_ff[7:0];
            ptr_in   = ptr_sum[AW-1:0];
            cnt_in   = cnt_ff + 32'd1;
            state_in = S_DONE;
         end
         S_INIT_MUL: begin
            prod_in  = mul_out[etbc_pkg::INIT_W-1:0];
            state_in = S_INIT_WR;
         end
         S_INIT_WR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[AW-1:0];
            wr_data = prod_ff[7:0] ^ prod_ff[etbc_pkg::INIT_W-1:etbc_pkg::FOLD_SHIFT]
                      ^ mask_ff;
            idx_in  = idx_ff + CW'(1);
            m257_in = (m257_ff == etbc_pkg::MOD_LAST) ? 9'd0 : m257_ff + 9'd1;
            if (idx_ff[AW-1:0] == IDX_LAST) begin
               ptr_in   = '0;
               cnt_in   = '0;
               state_in = S_DONE;
            end else begin
               state_in = S_INIT_MUL;
            end
         end
         S_HASH: begin
            // read runs one entry ahead of the hash update
            rd_addr = idx_ff[AW-1:0];
            idx_in  = idx_ff + CW'(1);
            if (idx_ff != '0) begin
               hash_in = mul_out;
            end
            if (idx_ff == SWEEP_END) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = (type_ff == etbc_pkg::REQ_ENCRYPT ||
                               type_ff == etbc_pkg::REQ_DECRYPT) ? out_ff : 8'd0;
               rsp_fp_in    = (type_ff == etbc_pkg::REQ_FPRINT) ? hash_ff : 32'd0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
         jump_ff <= '0;
         mask_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            etbc_pkg::CSR_SEED: seed_ff <= csr_wdata;
            etbc_pkg::CSR_JUMP: jump_ff <= csr_wdata[31:0];
            etbc_pkg::CSR_MASK: mask_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         idx_ff       <= '0;
         m257_ff      <= '0;
         ptr_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         m257_ff      <= m257_in;
         ptr_ff       <= ptr_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff     <= type_in;
      data_ff     <= data_in;
      out_ff      <= out_in;
      c_ff        <= c_in;
      hash_ff     <= hash_in;
      prod_ff     <= prod_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_fp_ff   <= rsp_fp_in;
   end

endmodule

`default_nettype wire

// ----- src/etbc_mem.sv -----
// Key table storage: one write port, one read port with registered data.
// No package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module etbc_mem #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output      logic [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- src/etbc_mul.sv -----
// Shared multiplier: FNV-1a step or init-entry product, low 32 bits.
// Depends on etbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module etbc_mul (
   input  wire etbc_pkg::mul_req_type op,
   output      logic [31:0]           product
);

   logic [31:0] a;
   logic [31:0] b;

   always_comb begin
      if (op.mode == etbc_pkg::MUL_FNV) begin
         a = op.hash ^ {24'd0, op.data};
         b = etbc_pkg::FNV_PRIME;
      end else begin
         a = {{(32 - etbc_pkg::INIT_W){1'b0}}, op.init_a};
         b = {{(32 - etbc_pkg::INIT_W){1'b0}}, op.init_b};
      end
      product = a * b;   // low 32 bits kept
   end

endmodule

`default_nettype wire

// ----- test/evolving_table_byte_cipher_test.sv -----
// Self-checking testbench for the evolving-table byte cipher top level.
// Depends on etbc_pkg and the etbc_req_if / etbc_rsp_if channel interfaces.
`timescale 1ns / 1ps

module evolving_table_byte_cipher_test;

   localparam int TABLE_SIZE = 256;
   localparam int IDX_W      = $clog2(TABLE_SIZE);
   localparam int INIT_MOD   = 257;          // index term of an init entry wraps here

   // request codes the block must ignore
   localparam logic [2:0] REQ_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] REQ_UNUSED_LAST  = 3'd7;
   // register index past the end of the register list; write is dropped
   localparam logic [1:0] CSR_NONE = 2'd3;

   localparam int STALL_LIMIT  = 4000;       // cycles without any item moving
   localparam int HOLD_CYCLES  = 300;        // long receiver hold-off
   localparam int DRAIN_CYCLES = 8;
   localparam int RANDOM_ITEMS = 1100;
   localparam int MAX_PRINTED  = 40;

   // one expected result item, tagged with the request that caused it
   typedef struct {
      logic [2:0]  code;
      logic [7:0]  result_byte;
      logic [31:0] fingerprint;
   } cipher_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        csr_we;
   logic [1:0]  csr_index;
   logic [63:0] csr_wdata;

   etbc_req_if req_ch ();
   etbc_rsp_if rsp_ch ();

   evolving_table_byte_cipher #(.TABLE_SIZE(TABLE_SIZE)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Cipher shadow: own copy of registers and state, advanced at the same
   // clock edges at which the block takes items and register writes.
   // ------------------------------------------------------------------
   logic [63:0]      seed_reg;
   logic [31:0]      jump_reg;
   logic [7:0]       mask_reg;
   logic [7:0]       key_tbl [TABLE_SIZE];
   logic [IDX_W-1:0] tbl_ptr;
   logic [31:0]      byte_cnt;

   cipher_result_type pending_results [$];   // oldest first
   logic [7:0]        cipher_log [$];        // ciphertext of each encrypt, for round trips

   int error_count  = 0;
   int results_seen = 0;
   int csr_writes   = 0;
   int code_count [8];

   // receiver pacing controls
   bit rsp_paced    = 1'b1;
   bit hold_off_req = 1'b0;
   // sender burst state
   int burst_left   = 0;

   task automatic report_error(string msg);
      error_count++;
      if (error_count <= MAX_PRINTED)
         $display("ERROR @%0t: %s", $time, msg);
   endtask

   function automatic cipher_result_type predict_item(logic [2:0] code, logic [7:0] din);
      cipher_result_type r;
      logic [IDX_W-1:0]  k;
      logic [7:0]        c;
      logic [31:0]       sum32;
      logic [31:0]       h;
      logic [63:0]       t;
      logic [63:0]       v;
      r.code        = code;
      r.result_byte = 8'h00;
      r.fingerprint = 32'h0;
      case (code)
         etbc_pkg::REQ_ENCRYPT, etbc_pkg::REQ_DECRYPT: begin
            k = tbl_ptr + byte_cnt[IDX_W-1:0];
            r.result_byte = din ^ key_tbl[k];
            // the table always evolves with the ciphertext byte
            c = (code == etbc_pkg::REQ_DECRYPT) ? din : r.result_byte;
            key_tbl[tbl_ptr] = key_tbl[tbl_ptr] ^ c ^ byte_cnt[7:0];
            tbl_ptr = tbl_ptr + IDX_W'(c) + 1'b1;
            byte_cnt = byte_cnt + 32'd1;
            if (code == etbc_pkg::REQ_ENCRYPT)
               cipher_log.push_back(r.result_byte);
         end
         etbc_pkg::REQ_INIT: begin
            for (int i = 0; i < TABLE_SIZE; i++) begin
               sum32 = jump_reg + 32'(i % INIT_MOD);
               t = {{32{sum32[31]}}, sum32};
               v = (64'(i) ^ seed_reg) * t;
               key_tbl[i] = v[7:0] ^ 8'(v >> etbc_pkg::FOLD_SHIFT) ^ mask_reg;
            end
            tbl_ptr  = '0;
            byte_cnt = 32'd0;
         end
         etbc_pkg::REQ_RESET: begin
            tbl_ptr  = '0;
            byte_cnt = 32'd0;
         end
         etbc_pkg::REQ_FPRINT: begin
            h = etbc_pkg::FNV_BASIS;
            for (int i = 0; i < TABLE_SIZE; i++) begin
               h = h ^ {24'd0, key_tbl[i]};
               h = h * etbc_pkg::FNV_PRIME;
            end
            r.fingerprint = h;
         end
         default: ;   // unused codes: no state change, zero result
      endcase
      return r;
   endfunction

   // Monitor: register writes, result check against the oldest expectation,
   // then prediction for a newly taken item. A result can never belong to an
   // item taken at the same edge, so this order is safe.
   always @(posedge clock) begin : monitor
      cipher_result_type want;
      if (reset) begin
         seed_reg = 64'd0;
         jump_reg = 32'd0;
         mask_reg = 8'd0;
         key_tbl  = '{default: 8'h00};
         tbl_ptr  = '0;
         byte_cnt = 32'd0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               etbc_pkg::CSR_SEED: seed_reg = csr_wdata;
               etbc_pkg::CSR_JUMP: jump_reg = csr_wdata[31:0];
               etbc_pkg::CSR_MASK: mask_reg = csr_wdata[7:0];
               default:  ;
            endcase
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_results.size() == 0) begin
               report_error($sformatf("result item with nothing pending: byte %02h fp %08h",
                                      rsp_ch.result_byte, rsp_ch.fingerprint));
            end else begin
               want = pending_results.pop_front();
               results_seen++;
               if (rsp_ch.result_byte !== want.result_byte)
                  report_error($sformatf("result %0d (req %0d) result_byte %02h, want %02h",
                                         results_seen, want.code, rsp_ch.result_byte,
                                         want.result_byte));
               if (rsp_ch.fingerprint !== want.fingerprint)
                  report_error($sformatf("result %0d (req %0d) fingerprint %08h, want %08h",
                                         results_seen, want.code, rsp_ch.fingerprint,
                                         want.fingerprint));
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            code_count[req_ch.req_type]++;
            pending_results.push_back(predict_item(req_ch.req_type, req_ch.data_byte));
         end
      end
   end

   // Watchdog: any stretch with no item moving on either channel.
   // Longest legal one is an init pass over the whole table.
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("TIMEOUT: no item moved for %0d cycles, %0d results pending",
               STALL_LIMIT, pending_results.size());
      $display("*** FAILED ***");
      $finish;
   end

   // Receiver: random ready runs, or always ready, or a long hold-off on request.
   initial begin : rsp_pacer
      int run_left;
      int hold_left;
      bit level;
      run_left  = 0;
      hold_left = 0;
      level     = 1'b1;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_left    = HOLD_CYCLES;
            hold_off_req = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (!rsp_paced) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            if (run_left == 0) begin
               level    = ($urandom_range(0, 3) != 0);
               run_left = level ? $urandom_range(1, 20) : $urandom_range(1, 6);
            end
            run_left--;
            rsp_ch.ready <= level;
         end
      end
   end

   // ------------------------------------------------------------------
   // Sender side
   // ------------------------------------------------------------------
   task automatic send_item(logic [2:0] code, logic [7:0] din);
      @(negedge clock);
      req_ch.valid     <= 1'b1;
      req_ch.req_type  <= code;
      req_ch.data_byte <= din;
      do
         @(posedge clock);
      while (!(req_ch.valid && req_ch.ready));
   endtask

   task automatic idle_sender(int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
   endtask

   // bursts of random length with random gaps in between
   task automatic send_paced(logic [2:0] code, logic [7:0] din);
      if (burst_left == 0) begin
         idle_sender($urandom_range(0, 12));
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      send_item(code, din);
   endtask

   // wait until every result is in, then a short pause: block is idle
   task automatic drain();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [63:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      csr_writes++;
   endtask

   // upper bits of jump and mask writes carry junk the block must drop
   task automatic load_config(logic [63:0] seed, logic [31:0] jump, logic [7:0] mask);
      write_csr(etbc_pkg::CSR_SEED, seed);
      write_csr(etbc_pkg::CSR_JUMP, {$urandom, jump});
      write_csr(etbc_pkg::CSR_MASK, {$urandom, 24'($urandom), mask});
   endtask

   function automatic logic [7:0] random_byte();
      case ($urandom_range(0, 9))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // table is all zero after reset: keystream zero, known fingerprint
   task automatic test_reset_state();
      send_item(etbc_pkg::REQ_FPRINT, 8'h00);
      send_item(etbc_pkg::REQ_ENCRYPT, 8'h00);
      send_item(etbc_pkg::REQ_ENCRYPT, 8'hFF);
      send_item(etbc_pkg::REQ_DECRYPT, 8'h5A);
      for (int code = REQ_UNUSED_FIRST; code <= REQ_UNUSED_LAST; code++)
         send_item(3'(code), 8'hFF);
      send_item(etbc_pkg::REQ_RESET, 8'hFF);
      send_item(etbc_pkg::REQ_FPRINT, 8'h00);
      drain();
   endtask

   // register extremes, sign-extended jump, jump wrap, dropped index
   task automatic test_csr_extremes();
      load_config(64'hFFFF_FFFF_FFFF_FFFF, 32'h8000_0000, 8'hFF);
      write_csr(CSR_NONE, 64'hDEAD_BEEF_0123_4567);
      send_item(etbc_pkg::REQ_INIT, 8'h00);
      send_item(etbc_pkg::REQ_FPRINT, 8'h00);
      send_item(etbc_pkg::REQ_ENCRYPT, 8'h00);
      send_item(etbc_pkg::REQ_ENCRYPT, 8'hFF);
      send_item(etbc_pkg::REQ_DECRYPT, 8'hA5);
      drain();
      // jump + index crosses from max positive into negative
      load_config(64'd0, 32'h7FFF_FFFF, 8'h00);
      send_item(etbc_pkg::REQ_INIT, 8'hFF);
      send_item(etbc_pkg::REQ_FPRINT, 8'hFF);
      send_item(etbc_pkg::REQ_ENCRYPT, 8'h81);
      drain();
      // small negative jump: sum passes through zero inside the table
      load_config(64'h0123_4567_89AB_CDEF, 32'hFFFF_FF80, 8'h3C);
      send_item(etbc_pkg::REQ_INIT, 8'h00);
      send_item(etbc_pkg::REQ_FPRINT, 8'h00);
      drain();
   endtask

   // encrypt after init, re-init, decrypt the ciphertext: plaintext returns
   task automatic test_round_trip();
      logic [7:0] plain [4];
      logic [7:0] cipher [$];
      plain = '{8'h00, 8'hFF, 8'h55, 8'hAA};
      cipher_log.delete();
      send_item(etbc_pkg::REQ_INIT, 8'h00);
      foreach (plain[i]) send_item(etbc_pkg::REQ_ENCRYPT, plain[i]);
      drain();
      cipher = cipher_log;
      send_item(etbc_pkg::REQ_INIT, 8'h00);
      foreach (cipher[i]) send_item(etbc_pkg::REQ_DECRYPT, cipher[i]);
      drain();
   endtask

   // receiver holds off while items keep coming: block fills and stalls input
   task automatic test_backpressure();
      rsp_paced    = 1'b0;
      hold_off_req = 1'b1;
      for (int i = 0; i < 24; i++)
         send_item(($urandom_range(0, 1) != 0) ? etbc_pkg::REQ_ENCRYPT
                                               : etbc_pkg::REQ_DECRYPT, random_byte());
      drain();
      rsp_paced = 1'b1;
   endtask

   function automatic logic [2:0] random_code();
      int r;
      r = $urandom_range(0, 99);
      if (r < 44)      return etbc_pkg::REQ_ENCRYPT;
      else if (r < 84) return etbc_pkg::REQ_DECRYPT;
      else if (r < 88) return etbc_pkg::REQ_RESET;
      else if (r < 92) return etbc_pkg::REQ_FPRINT;
      else if (r < 95) return etbc_pkg::REQ_INIT;
      else             return 3'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST));
   endfunction

   // phases: new settings while idle, then init and a long random byte stream
   task automatic test_random_streams();
      int per_phase;
      int sent;
      logic [31:0] jump;
      per_phase = RANDOM_ITEMS / 8;
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: load_config(64'd0, 32'h7FFF_FFFF, 8'h00);
            1: load_config(64'hFFFF_FFFF_FFFF_FFFF, 32'h8000_0000, 8'hFF);
            2: load_config({$urandom, $urandom}, 32'hFFFF_FFFF, 8'($urandom));
            3: load_config(64'd0, 32'd0, 8'd0);
            default: begin
               jump = ($urandom_range(0, 1) != 0) ? $urandom
                                                  : -32'($urandom_range(0, 300));
               load_config({$urandom, $urandom}, jump, 8'($urandom));
            end
         endcase
         // phases 1, 4 and 7 run without receiver stalls, phases 3 and 7 without sender gaps
         rsp_paced = (phase % 3 != 1);
         sent = 0;
         send_paced(etbc_pkg::REQ_INIT, random_byte());
         while (sent < per_phase) begin
            if (phase % 4 == 3)
               send_item(random_code(), random_byte());
            else
               send_paced(random_code(), random_byte());
            sent++;
         end
         send_paced(etbc_pkg::REQ_FPRINT, random_byte());
         drain();
      end
      rsp_paced = 1'b1;
   endtask

   task automatic finish_run();
      drain();
      repeat (16) @(posedge clock);
      if (pending_results.size() != 0)
         report_error($sformatf("%0d expected results never arrived",
                                pending_results.size()));
      $display("Covered %0d results: %0d encrypt, %0d decrypt, %0d init, %0d fingerprint,",
               results_seen, code_count[etbc_pkg::REQ_ENCRYPT],
               code_count[etbc_pkg::REQ_DECRYPT],
               code_count[etbc_pkg::REQ_INIT], code_count[etbc_pkg::REQ_FPRINT]);
      $display("  %0d position resets, %0d unused codes, %0d register writes, %0d errors.",
               code_count[etbc_pkg::REQ_RESET],
               code_count[5] + code_count[6] + code_count[7], csr_writes, error_count);
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   endtask

   initial begin
      req_ch.valid     = 1'b0;
      req_ch.req_type  = etbc_pkg::REQ_RESET;
      req_ch.data_byte = 8'h00;
      csr_we           = 1'b0;
      csr_index        = etbc_pkg::CSR_SEED;
      csr_wdata        = 64'd0;
      foreach (code_count[i]) code_count[i] = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // block clears its table after reset with input not ready; send waits it out
      test_reset_state();
      test_csr_extremes();
      test_round_trip();
      test_backpressure();
      test_random_streams();
      finish_run();
   end

endmodule

// ----- sim.f -----
src/etbc_pkg.sv
src/etbc_intf.sv
src/etbc_mem.sv
src/etbc_mul.sv
src/evolving_table_byte_cipher.sv
test/evolving_table_byte_cipher_test.sv
